// ===== sv/selt_pkg.sv =====
package selt_pkg;

	localparam int DEF_TABLE_ENTRIES = 16;
	localparam int OP_W = 3;
	localparam int KEY_W = 32;
	localparam int CNT_W = 8;
	localparam int ST_W = 3;
	localparam int ENTRY_W = 3 * KEY_W + 1 + CNT_W;

	localparam logic [OP_W-1:0] OP_OPEN = 3'd0;
	localparam logic [OP_W-1:0] OP_CLOSE = 3'd1;
	localparam logic [OP_W-1:0] OP_PURGE_OWNER = 3'd2;
	localparam logic [OP_W-1:0] OP_PURGE_FILE = 3'd3;
	localparam logic [OP_W-1:0] OP_CHANGE = 3'd4;

	localparam logic [ST_W-1:0] ST_OK = 3'd0;
	localparam logic [ST_W-1:0] ST_REFUSED = 3'd1;
	localparam logic [ST_W-1:0] ST_NOT_OPEN = 3'd2;
	localparam logic [ST_W-1:0] ST_NO_PERM = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL = 3'd4;
	localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd5;

	localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

	typedef struct packed {
		logic [KEY_W-1:0] inode;
		logic [KEY_W-1:0] dnode;
		logic [KEY_W-1:0] owner;
		logic excl;
		logic [CNT_W-1:0] count;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_APPEND,
		S_HELD,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic rd_start;
		logic step;
		logic append;
		logic held_wr;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
		logic finish;
		logic empty;
	} sts_t;

endpackage

// ===== sv/selt_ram.sv =====
module selt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/selt_datapath.sv =====
module selt_datapath #(
	parameter int TABLE_ENTRIES = selt_pkg::DEF_TABLE_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	input selt_pkg::cmd_t cmd,
	output selt_pkg::sts_t sts,
	input logic install_ok_q,
	input logic [2:0] operation,
	input logic checked,
	input logic want_exclusive,
	input logic [31:0] owner_id,
	input logic [31:0] inode_key,
	input logic [31:0] dnode_key,
	output logic [2:0] status_q
);
	import selt_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int NW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [NW-1:0] FULL_N = NW'(TABLE_ENTRIES);

	logic [NW-1:0] n_q, rd_q, wr_q;
	logic [OP_W-1:0] op_q;
	logic ex_q;
	logic [KEY_W-1:0] own_q, ino_q, dno_q;
	logic held_q;
	logic [AW-1:0] held_idx_q;
	entry_t held_ent_q;
	// after a finishing hit with compaction pending, the remaining entries
	// still stream through as plain copies
	logic fin_seen_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	entry_t wdata, rdata_e;
	logic [ENTRY_W-1:0] rdata;

	assign rdata_e = entry_t'(rdata);

	selt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(ENTRY_W'(wdata)),
		.raddr(raddr), .rdata(rdata)
	);

	logic file_m, own_m, drop, keep, fin;
	logic [ST_W-1:0] st;
	entry_t upd;

	always_comb begin
		file_m = (rdata_e.inode == ino_q) && (rdata_e.dnode == dno_q);
		own_m = rdata_e.owner == own_q;
		drop = 1'b0;
		fin = 1'b0;
		st = ST_OK;
		upd = rdata_e;
		case (op_q)
			OP_OPEN: begin
				if (file_m) begin
					if (own_m) begin
						fin = 1'b1;
						if (ex_q || rdata_e.excl || rdata_e.count >= COUNT_MAX) begin
							st = ST_REFUSED;
						end else begin
							upd.count = rdata_e.count + 8'd1;
						end
					end else if (ex_q || rdata_e.excl) begin
						fin = 1'b1;
						st = ST_REFUSED;
					end
				end
			end
			OP_CLOSE: begin
				if (file_m && own_m) begin
					fin = 1'b1;
					upd.count = rdata_e.count - 8'd1;
					drop = (upd.count == '0);
				end
			end
			OP_PURGE_OWNER: drop = (own_q == '0) || own_m;
			OP_PURGE_FILE: drop = (rdata_e.inode == ino_q) &&
				((dno_q == '0) || (rdata_e.dnode == dno_q));
			OP_CHANGE: begin
				if (file_m) begin
					if (!own_m) begin
						if (ex_q) begin
							fin = 1'b1;
							st = ST_REFUSED;
						end
					end else if (!ex_q) begin
						fin = 1'b1;
						upd.excl = 1'b0;
					end else if (rdata_e.count > 8'd1) begin
						fin = 1'b1;
						st = ST_REFUSED;
					end else if (rdata_e.excl) begin
						fin = 1'b1;
					end else if (held_q) begin
						fin = 1'b1;
						st = ST_REFUSED;
					end
				end
			end
			default: ;
		endcase
		if (fin_seen_q) begin
			fin = 1'b0;
			drop = 1'b0;
		end
		keep = !drop;
	end

	logic is_last;
	assign is_last = (rd_q + NW'(1)) >= n_q;

	// early finish keeps untouched tail in place when nothing was dropped
	logic clean_fin;
	assign clean_fin = fin && (wr_q == rd_q) && !drop;

	assign sts.last = is_last;
	assign sts.finish = clean_fin;
	assign sts.empty = (n_q == '0);

	always_comb begin
		raddr = rd_q[AW-1:0];
		if (cmd.step) begin
			raddr = AW'(rd_q + NW'(1));
		end
		if (cmd.rd_start) begin
			raddr = '0;
		end
		we = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = fin ? upd : rdata_e;
		if (cmd.step && keep) begin
			we = 1'b1;
		end
		if (cmd.append && n_q != FULL_N) begin
			we = 1'b1;
			waddr = n_q[AW-1:0];
			wdata.inode = ino_q;
			wdata.dnode = dno_q;
			wdata.owner = own_q;
			wdata.excl = ex_q;
			wdata.count = 8'd1;
		end
		if (cmd.held_wr && held_q) begin
			we = 1'b1;
			waddr = held_idx_q;
			wdata = held_ent_q;
			wdata.excl = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			held_q <= 1'b0;
			fin_seen_q <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (cmd.load) begin
				op_q <= operation;
				ex_q <= want_exclusive;
				own_q <= owner_id;
				ino_q <= inode_key;
				dno_q <= dnode_key;
				rd_q <= '0;
				wr_q <= '0;
				held_q <= 1'b0;
				fin_seen_q <= 1'b0;
				status_q <= ST_OK;
				if (operation > OP_CHANGE) begin
					status_q <= ST_UNKNOWN;
				end else if (operation == OP_OPEN && checked && !install_ok_q) begin
					status_q <= ST_NO_PERM;
				end
			end
			if (cmd.step) begin
				rd_q <= rd_q + NW'(1);
				if (fin_seen_q) begin
					wr_q <= wr_q + NW'(1);
				end else begin
					if (keep) begin
						wr_q <= wr_q + NW'(1);
					end
					if (fin) begin
						fin_seen_q <= 1'b1;
						status_q <= st;
					end else if (op_q == OP_CHANGE && file_m && own_m && ex_q) begin
						held_q <= 1'b1;
						held_idx_q <= wr_q[AW-1:0];
						held_ent_q <= rdata_e;
					end
				end
				if (is_last || clean_fin) begin
					if (!clean_fin) begin
						n_q <= (fin_seen_q || keep) ? wr_q + NW'(1) : wr_q;
					end
				end
			end
			if (cmd.append) begin
				if (n_q == FULL_N) begin
					status_q <= ST_FULL;
				end else begin
					n_q <= n_q + NW'(1);
				end
			end
			if (cmd.held_wr) begin
				status_q <= held_q ? ST_OK : ST_NOT_OPEN;
			end
		end
	end
endmodule

// ===== sv/selt_ctrl.sv =====
module selt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input logic [2:0] operation,
	input logic checked,
	input logic install_ok_q,
	input logic [31:0] inode_key,
	input selt_pkg::sts_t sts,
	input logic [2:0] status_q,
	output selt_pkg::cmd_t cmd
);
	import selt_pkg::*;

	state_t state_q, state_d;
	logic [OP_W-1:0] op_q;
	logic fin_q;
	logic skip;

	assign skip = (operation > OP_CHANGE) ||
		(operation == OP_OPEN && checked && !install_ok_q) ||
		(operation == OP_PURGE_FILE && inode_key == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) begin
				if (skip) state_d = S_DONE;
				else if (sts.empty) state_d = (operation == OP_OPEN) ? S_APPEND :
					(operation == OP_CHANGE) ? S_HELD : S_DONE;
				else state_d = S_READ;
			end
			S_READ: state_d = S_EVAL;
			S_EVAL: begin
				if (sts.finish) state_d = S_DONE;
				else if (sts.last) begin
					if (fin_q || status_q != ST_OK) state_d = S_DONE;
					else if (op_q == OP_OPEN) state_d = S_APPEND;
					else if (op_q == OP_CHANGE) state_d = S_HELD;
					else state_d = S_DONE;
				end
			end
			S_APPEND: state_d = S_DONE;
			S_HELD: state_d = S_DONE;
			S_DONE: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.rd_start = in_valid;
			end
			S_EVAL: cmd.step = 1'b1;
			S_APPEND: cmd.append = 1'b1;
			S_HELD: cmd.held_wr = 1'b1;
			S_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_OPEN;
			fin_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				op_q <= operation;
				fin_q <= 1'b0;
			end
			if (cmd.step && status_q != ST_OK) fin_q <= 1'b1;
		end
	end
endmodule

// ===== sv/shared_exclusive_lock_table_core.sv =====
// Ordered file lock table. One request is taken at a time; each returns one
// status. A request reads the table once through its single RAM read port,
// one entry a cycle, compacting in place, followed where needed by an append
// or a change-mode write. The table starts empty after reset; no clearing
// pass is needed.
module shared_exclusive_lock_table_core #(
	parameter int TABLE_ENTRIES = selt_pkg::DEF_TABLE_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] operation,
	input logic checked,
	input logic want_exclusive,
	input logic [31:0] owner_id,
	input logic [31:0] inode_key,
	input logic [31:0] dnode_key,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] status
);
	import selt_pkg::*;

	logic install_ok_q;
	cmd_t cmd;
	sts_t sts;
	logic [2:0] status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			install_ok_q <= 1'b1;
		end else if (cfg_we) begin
			install_ok_q <= cfg_wdata;
		end
	end

	selt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .operation(operation),
		.checked(checked), .install_ok_q(install_ok_q), .inode_key(inode_key),
		.sts(sts), .status_q(status_q), .cmd(cmd)
	);

	selt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.install_ok_q(install_ok_q), .operation(operation), .checked(checked),
		.want_exclusive(want_exclusive), .owner_id(owner_id),
		.inode_key(inode_key), .dnode_key(dnode_key), .status_q(status_q)
	);

	assign status = status_q;
endmodule

// ===== bench/lock_table_checker.sv =====
`timescale 1ns / 1ps
module lock_table_checker
	import selt_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	input logic in_valid,
	input logic in_ready,
	input logic [2:0] operation,
	input logic checked,
	input logic want_exclusive,
	input logic [31:0] owner_id,
	input logic [31:0] inode_key,
	input logic [31:0] dnode_key,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] status,
	output int errors,
	output int pending
);
	entry_t lock_tbl[$];
	logic install_ok;
	logic [ST_W-1:0] status_q[$];

	assign pending = status_q.size();

	function automatic logic [ST_W-1:0] open_lock(logic ex, logic [31:0] own, logic [31:0] ino,
			logic [31:0] dno);
		entry_t e;
		foreach (lock_tbl[i]) begin
			if (lock_tbl[i].inode != ino || lock_tbl[i].dnode != dno)
				continue;
			if (lock_tbl[i].owner == own) begin
				if (ex || lock_tbl[i].excl || lock_tbl[i].count == COUNT_MAX)
					return ST_REFUSED;
				lock_tbl[i].count++;
				return ST_OK;
			end
			if (ex || lock_tbl[i].excl)
				return ST_REFUSED;
		end
		if (lock_tbl.size() >= TABLE_ENTRIES)
			return ST_FULL;
		e.inode = ino;
		e.dnode = dno;
		e.owner = own;
		e.excl = ex;
		e.count = 1;
		lock_tbl.push_back(e);
		return ST_OK;
	endfunction

	function automatic logic [ST_W-1:0] change_mode(logic ex, logic [31:0] own,
			logic [31:0] ino, logic [31:0] dno);
		int held;
		held = -1;
		foreach (lock_tbl[i]) begin
			if (lock_tbl[i].inode != ino || lock_tbl[i].dnode != dno)
				continue;
			if (lock_tbl[i].owner != own) begin
				if (ex)
					return ST_REFUSED;
				continue;
			end
			if (!ex) begin
				lock_tbl[i].excl = 1'b0;
				return ST_OK;
			end
			if (lock_tbl[i].count > 1)
				return ST_REFUSED;
			if (lock_tbl[i].excl)
				return ST_OK;
			if (held >= 0)
				return ST_REFUSED;
			held = i;
		end
		if (held < 0)
			return ST_NOT_OPEN;
		lock_tbl[held].excl = 1'b1;
		return ST_OK;
	endfunction

	function automatic logic [ST_W-1:0] lock_status(logic [2:0] op, logic chk, logic ex,
			logic [31:0] own, logic [31:0] ino, logic [31:0] dno);
		int i;
		i = 0;
		case (op)
			OP_OPEN: begin
				if (chk && !install_ok)
					return ST_NO_PERM;
				return open_lock(ex, own, ino, dno);
			end
			OP_CLOSE: begin
				foreach (lock_tbl[k])
					if (lock_tbl[k].inode == ino && lock_tbl[k].dnode == dno
							&& lock_tbl[k].owner == own) begin
						lock_tbl[k].count--;
						if (lock_tbl[k].count == 0)
							lock_tbl.delete(k);
						break;
					end
				return ST_OK;
			end
			OP_PURGE_OWNER: begin
				while (i < lock_tbl.size())
					if (own == 0 || lock_tbl[i].owner == own)
						lock_tbl.delete(i);
					else
						i++;
				return ST_OK;
			end
			OP_PURGE_FILE: begin
				if (ino != 0)
					while (i < lock_tbl.size())
						if (lock_tbl[i].inode == ino && (dno == 0 || lock_tbl[i].dnode == dno))
							lock_tbl.delete(i);
						else
							i++;
				return ST_OK;
			end
			OP_CHANGE: return change_mode(ex, own, ino, dno);
			default: return ST_UNKNOWN;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_tbl.delete();
			status_q.delete();
			install_ok <= 1'b1;
			errors <= 0;
		end else begin
			if (cfg_we)
				install_ok <= cfg_wdata;
			if (in_valid && in_ready)
				status_q.push_back(lock_status(operation, checked, want_exclusive,
					owner_id, inode_key, dnode_key));
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected transfer: status %0d", status);
					errors <= errors + 1;
				end else begin
					if (status !== status_q[0]) begin
						if (errors < 10)
							$display("status mismatch: expected %0d actual %0d",
								status_q[0], status);
						errors <= errors + 1;
					end
					void'(status_q.pop_front());
				end
			end
		end
	end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import selt_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic checked = 1'b0;
	logic want_exclusive = 1'b0;
	logic [31:0] owner_id = '0;
	logic [31:0] inode_key = '0;
	logic [31:0] dnode_key = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	int errors;
	int pending;
	int idle_cycles = 0;
	logic [31:0] owners[4];
	logic [31:0] inodes[4];
	logic [31:0] dnodes[3];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	shared_exclusive_lock_table_core u_top (.*);

	lock_table_checker u_chk (.*);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver stall pattern: phases of no stall, light and heavy stalling
	initial begin
		int mode;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_lock_req(logic [2:0] op, logic chk, logic ex, logic [31:0] own,
			logic [31:0] ino, logic [31:0] dno);
		in_valid <= 1'b1;
		operation <= op;
		checked <= chk;
		want_exclusive <= ex;
		owner_id <= own;
		inode_key <= ino;
		dnode_key <= dno;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic lower_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		lower_valid();
		while (pending != 0)
			@(posedge clk);
		repeat (60)
			@(posedge clk);
	endtask

	task automatic set_install(logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_req();
		logic [2:0] op;
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			op = OP_OPEN;
		else if (r < 65)
			op = OP_CLOSE;
		else if (r < 72)
			op = OP_PURGE_OWNER;
		else if (r < 80)
			op = OP_PURGE_FILE;
		else if (r < 97)
			op = OP_CHANGE;
		else
			op = 3'($urandom_range(5, 7));
		if ($urandom_range(0, 19) == 0)
			send_lock_req(op, 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom);
		else
			send_lock_req(op, 1'($urandom), 1'($urandom),
				($urandom_range(0, 40) == 0) ? 32'd0 : owners[$urandom_range(0, 3)],
				($urandom_range(0, 40) == 0) ? 32'd0 : inodes[$urandom_range(0, 3)],
				($urandom_range(0, 10) == 0) ? 32'd0 : dnodes[$urandom_range(0, 2)]);
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		send_lock_req(OP_OPEN, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_lock_req(OP_OPEN, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_lock_req(OP_OPEN, 1'b0, 1'b1, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_lock_req(OP_CHANGE, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_lock_req(OP_CLOSE, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_lock_req(OP_CHANGE, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_lock_req(OP_CHANGE, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_lock_req(OP_CHANGE, 1'b0, 1'b1, 32'd9, 32'd1, 32'd1);
		send_lock_req(OP_PURGE_FILE, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0);
		send_lock_req(OP_PURGE_FILE, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0);
		send_lock_req(OP_PURGE_OWNER, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0);
		for (int i = 5; i <= 7; i++)
			send_lock_req(3'(i), 1'b1, 1'b1, 32'd1, 32'd1, 32'd1);
		for (int i = 0; i < 17; i++)
			send_lock_req(OP_OPEN, 1'b0, 1'b0, 32'd0, 32'(i + 1), 32'd0);
		send_lock_req(OP_PURGE_OWNER, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0);
		// share count up to its ceiling
		for (int i = 0; i < 256; i++)
			send_lock_req(OP_OPEN, 1'b0, 1'b0, 32'd7, 32'd3, 32'd3);
		send_lock_req(OP_PURGE_OWNER, 1'b0, 1'b0, 32'd7, 32'd0, 32'd0);
		drain();
		set_install(1'b0);
		send_lock_req(OP_OPEN, 1'b1, 1'b0, 32'd1, 32'd1, 32'd1);
		send_lock_req(OP_OPEN, 1'b0, 1'b0, 32'd1, 32'd1, 32'd1);
		drain();
		set_install(1'b1);
		// random phases
		for (int phase = 0; phase < 6; phase++) begin
			foreach (owners[k])
				owners[k] = (phase == 5) ? $urandom : 32'($urandom_range(1, 6));
			foreach (inodes[k])
				inodes[k] = (phase == 5) ? $urandom : 32'($urandom_range(1, 5));
			foreach (dnodes[k])
				dnodes[k] = (phase == 5) ? $urandom : 32'($urandom_range(1, 3));
			for (int n = 0; n < 210;) begin
				int burst;
				burst = $urandom_range(1, 30);
				for (int b = 0; b < burst && n < 210; b++, n++)
					random_req();
				if ($urandom_range(0, 2) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 40))
						@(posedge clk);
				end
			end
			drain();
			set_install((phase % 2) != 0);
		end
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
